@@ hw/rtl/qdd_pkg.sv @@
package qdd_pkg;

    localparam int CODE_W = 2;
    localparam int SUM_W  = 4;
    localparam int THR_W  = 3;

    typedef logic [CODE_W-1:0]      code_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [THR_W-1:0]       thr_t;

    typedef enum logic {
        MODE_STEP   = 1'b0,
        MODE_RESYNC = 1'b1
    } mode_t;

    typedef enum logic {
        DIR_CW  = 1'b0,
        DIR_CCW = 1'b1
    } dir_t;

    localparam code_t IDLE_CODE     = 2'b11;
    localparam sum_t  SUM_ZERO      = 4'sd0;
    localparam thr_t  THR_RESET     = 3'd3;
    localparam thr_t  THR_MIN       = 3'd1;

    // step state carried between items
    typedef struct packed {
        code_t prev_code;
        sum_t  step_sum;
    } step_state_t;

    typedef struct packed {
        logic emit;
        dir_t direction;
    } step_res_t;

    // transition table: {previous code, new code} -> -1, 0, +1
    function automatic logic signed [1:0] step_delta(input code_t prev_code, input code_t code);
        logic signed [1:0] delta;
        delta = 2'sd0;
        unique case ({prev_code, code}) inside
            4'd2, 4'd4, 4'd11, 4'd13: delta = 2'sd1;
            4'd1, 4'd7, 4'd8, 4'd14:  delta = -2'sd1;
            default:                  delta = 2'sd0;
        endcase
        return delta;
    endfunction

endpackage

@@ hw/rtl/qdd_if.sv @@
interface qdd_phase_if;
    import qdd_pkg::*;

    logic valid;
    logic ready;
    logic mode;
    logic clk_level;
    logic dt_level;

    modport source (output valid, output mode, output clk_level, output dt_level, input ready);
    modport sink   (input valid, input mode, input clk_level, input dt_level, output ready);
endinterface

interface qdd_detent_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

interface qdd_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] step_threshold;

    modport source (output valid, output step_threshold, input ready);
    modport sink   (input valid, input step_threshold, output ready);
endinterface

@@ hw/rtl/qdd_step.sv @@
module qdd_step
    import qdd_pkg::*;
(
    input  step_state_t state,
    input  mode_t       mode,
    input  code_t       code,
    input  thr_t        step_threshold,
    output step_state_t state_next,
    output step_res_t   res
);

    logic signed [1:0]     delta;
    logic signed [SUM_W:0] sum_raw;
    logic signed [SUM_W:0] sum_sat;
    logic signed [SUM_W:0] thr_pos;
    thr_t                  thr_eff;

    always_comb
    begin
        thr_eff = (step_threshold == '0) ? THR_MIN : step_threshold;
        thr_pos = signed'({{(SUM_W+1-THR_W){1'b0}}, thr_eff});
        delta   = step_delta(state.prev_code, code);
        sum_raw = {state.step_sum[SUM_W-1], state.step_sum}
                  + {{(SUM_W-1){delta[1]}}, delta};
        if (sum_raw > 5'sd7)
            sum_sat = 5'sd7;
        else if (sum_raw < -5'sd7)
            sum_sat = -5'sd7;
        else
            sum_sat = sum_raw;

        state_next.prev_code = code;
        state_next.step_sum  = SUM_ZERO;
        res.emit             = 1'b0;
        res.direction        = DIR_CW;

        if (mode == MODE_STEP)
        begin
            if (code != IDLE_CODE)
                state_next.step_sum = sum_sat[SUM_W-1:0];
            else if (sum_sat >= thr_pos)
                res.emit = 1'b1;
            else if (sum_sat <= -thr_pos)
            begin
                res.emit      = 1'b1;
                res.direction = DIR_CCW;
            end
        end
    end

endmodule

@@ hw/rtl/quadrature_detent_decoder.sv @@
// Quadrature detent decoder.
// phase:  one transfer per encoder sample; mode 0 steps the decoder with the
//         clk_level/dt_level pair, mode 1 resyncs (last code loaded, step count
//         cleared, never a detent).
// detent: one transfer per detected detent, direction 0 clockwise,
//         1 counterclockwise. Samples that complete no detent give nothing.
// cfg:    writes step_threshold (always ready); the user writes it only while
//         the block is idle, which the block does not enforce.
// A sample passes the input register, then the result register, on its way
// to the detent channel. Throughput: one sample per cycle unless a detent
// stalls; the step table, adder and threshold compare sit in the single stage
// between the two registers. When the receiver stalls the result register
// holds its detent and the input register still drains samples that emit
// nothing; a second pending detent stops phase.ready until the first one
// is taken. Reset: last code idle (both high), step count zero, threshold 3,
// both registers empty.
module quadrature_detent_decoder
    import qdd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    qdd_phase_if.sink     phase,
    qdd_detent_if.source  detent,
    qdd_cfg_if.sink       cfg
);

    logic        in_valid_reg;
    mode_t       in_mode_reg;
    code_t       in_code_reg;
    logic        out_valid_reg;
    dir_t        out_dir_reg;
    thr_t        thr_reg;
    step_state_t state_reg;

    step_state_t state_next;
    step_res_t   res;
    logic        out_free;
    logic        s1_adv;

    qdd_step u_step (
        .state          (state_reg),
        .mode           (in_mode_reg),
        .code           (in_code_reg),
        .step_threshold (thr_reg),
        .state_next     (state_next),
        .res            (res)
    );

    assign out_free     = !out_valid_reg || detent.ready;
    assign s1_adv       = in_valid_reg && (out_free || !res.emit);
    assign phase.ready  = !in_valid_reg || s1_adv;
    assign cfg.ready    = 1'b1;
    assign detent.valid = out_valid_reg;
    assign detent.direction = out_dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            thr_reg             <= THR_RESET;
            state_reg.prev_code <= IDLE_CODE;
            state_reg.step_sum  <= SUM_ZERO;
        end
        else
        begin
            if (cfg.valid)
                thr_reg <= cfg.step_threshold;

            if (phase.ready)
                in_valid_reg <= phase.valid;

            if (s1_adv)
                state_reg <= state_next;

            if (s1_adv && res.emit)
                out_valid_reg <= 1'b1;
            else if (detent.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (phase.valid && phase.ready)
        begin
            in_mode_reg <= mode_t'(phase.mode);
            in_code_reg <= {phase.clk_level, phase.dt_level};
        end
        if (s1_adv && res.emit)
            out_dir_reg <= res.direction;
    end

endmodule
